// File: hw/rtl/rypp_pkg.sv
// ----------------------------------------------------------------------------
// rypp_pkg
// Shared types and constants for the Y-rotation perspective projection unit.
// ----------------------------------------------------------------------------
package rypp_pkg;

   // angle units: 1/64 degree
   localparam int unsigned ANGLE_FULL    = 23040;
   localparam int unsigned ANGLE_3Q      = 17280;
   localparam int unsigned ANGLE_HALF    = 11520;
   localparam int unsigned ANGLE_QUARTER = 5760;

   // divider operand widths
   localparam int unsigned DIV_NUM_W = 36;
   localparam int unsigned DIV_DEN_W = 18;

   // front/back queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;

   // output saturation limits
   localparam logic signed [37:0] OUT_MAX = 38'sd8388607;
   localparam logic signed [37:0] OUT_MIN = -38'sd8388608;

   // register reset values
   localparam logic [14:0] CAMERA_DISTANCE_RST = 15'd20480;
   localparam logic [14:0] NEAR_LIMIT_RST      = 15'd410;
   localparam logic [11:0] FOCAL_LENGTH_RST    = 12'd500;
   localparam logic [11:0] CENTER_X_RST        = 12'd500;
   localparam logic [11:0] CENTER_Y_RST        = 12'd400;

   typedef enum logic [2:0] {
      CSR_CAMERA_DISTANCE = 3'd0,
      CSR_NEAR_LIMIT      = 3'd1,
      CSR_FOCAL_LENGTH    = 3'd2,
      CSR_CENTER_X        = 3'd3,
      CSR_CENTER_Y        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic signed [15:0] vertex_z;
      logic signed [15:0] angle;
   } req_data_type;

   typedef struct packed {
      logic signed [23:0] screen_x;
      logic signed [23:0] screen_y;
      logic               depth_clamped;
   } rsp_data_type;

   typedef struct packed {
      logic [14:0] camera_distance;
      logic [14:0] near_limit;
      logic [11:0] focal_length;
      logic [11:0] center_x;
      logic [11:0] center_y;
   } cfg_type;

   // one divide job: rounded-division dividends, shared divisor, signs
   typedef struct packed {
      logic [DIV_NUM_W-1:0] num_x;
      logic [DIV_NUM_W-1:0] num_y;
      logic [DIV_DEN_W-1:0] den;
      logic                 neg_x;
      logic                 neg_y;
      logic                 clamped;
   } div_req_type;

endpackage

// File: hw/rtl/rypp_front.sv
// ----------------------------------------------------------------------------
// rypp_front
// Angle reduction, sine/cosine lookup, Y rotation, depth clamp and setup of
// the rounded divisions. Fully pipelined, one transaction per cycle.
// ----------------------------------------------------------------------------
module rypp_front
   import rypp_pkg::*;
#(
   parameter int unsigned SINE_TABLE_ENTRIES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   input  req_data_type in_data,
   output logic         out_valid,
   output div_req_type  out_data
);

   localparam int unsigned IDX_W   = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int unsigned Q_W     = IDX_W + 1;
   localparam int unsigned V_W     =
      $clog2(ANGLE_QUARTER * SINE_TABLE_ENTRIES + ANGLE_QUARTER / 2 + 1);
   localparam longint unsigned RECIP = (64'd1 << V_W) / ANGLE_QUARTER;
   localparam int unsigned RECIP_W = $clog2(RECIP + 1);
   localparam int unsigned P_W     = V_W + RECIP_W;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned SERIES_DIV [0:8] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};

   typedef logic [14:0] rom_type [0:SINE_TABLE_ENTRIES];

   // quarter-wave sine table, Q1.14, built from a Taylor series at elaboration
   function automatic rom_type build_rom();
      rom_type         t;
      longint unsigned x, x2, term, pos, neg, s, ii;
      for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
         ii   = 64'(i);
         x    = (ii * PI_Q30) / (2 * SINE_TABLE_ENTRIES);
         x2   = (x * x) >> 30;
         term = x;
         pos  = x;
         neg  = 0;
         for (int k = 1; k <= 9; k++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[k-1];
            if ((k % 2) == 1) neg = neg + term;
            else pos = pos + term;
         end
         s = (pos > neg) ? pos - neg : 64'd0;
         s = (s + 64'd32768) >> 16;
         if (s > 64'd16384) s = 64'd16384;
         t[i] = s[14:0];
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [9:0]          vld_ff;
   req_data_type        item_ff [0:7];

   logic [14:0]         a_ff [0:1];
   logic [V_W-1:0]      v1_ff [0:1];
   logic [V_W-1:0]      v2_ff [0:1];
   logic [P_W-1:0]      prod_ff [0:1];
   logic [IDX_W-1:0]    idx_ff [0:1];
   logic [14:0]         mag_ff [0:1];
   logic signed [15:0]  trig_ff [0:1];
   logic [1:0]          neg_ff [1:4];

   logic signed [31:0]  xc_ff, zs_ff, zc_ff, xs_ff;
   logic signed [18:0]  xr_ff, zr_ff;
   logic [16:0]         d_ff;
   logic                clamp_ff;
   logic signed [31:0]  numx_ff;
   logic signed [28:0]  numy_ff;

   div_req_type         out_ff;

   // valid pipe and vertex carry
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[8:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      item_ff[0] <= in_data;
      for (int k = 1; k <= 7; k++) item_ff[k] <= item_ff[k-1];
   end

   // stage 0: reduce angle to [0, full turn), derive cosine angle
   logic signed [16:0] ang;
   logic [14:0]        a_red, a_cos;
   always_comb begin
      ang = 17'(in_data.angle);
      priority if (ang >= 17'sd23040) a_red = 15'(ang - 17'sd23040);
      else if (ang >= 17'sd0) a_red = 15'(ang);
      else if (ang >= -17'sd23040) a_red = 15'(ang + 17'sd23040);
      else a_red = 15'(ang + 17'sd46080);
      a_cos = (a_red >= 15'(ANGLE_3Q)) ? a_red - 15'(ANGLE_3Q) : a_red + 15'(ANGLE_QUARTER);
   end

   always_ff @(posedge clock) begin
      a_ff[0] <= a_red;
      a_ff[1] <= a_cos;
   end

   // stage 1: quadrant fold, scaled table position
   logic [14:0] r_in [0:1];
   logic [12:0] u_in [0:1];
   logic [1:0]  neg_in;
   logic [V_W-1:0] v_in [0:1];
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         priority if (a_ff[j] >= 15'(ANGLE_3Q)) begin
            r_in[j] = a_ff[j] - 15'(ANGLE_3Q);
            u_in[j] = 13'(15'(ANGLE_QUARTER) - r_in[j]);
            neg_in[j] = 1'b1;
         end else if (a_ff[j] >= 15'(ANGLE_HALF)) begin
            r_in[j] = a_ff[j] - 15'(ANGLE_HALF);
            u_in[j] = 13'(r_in[j]);
            neg_in[j] = 1'b1;
         end else if (a_ff[j] >= 15'(ANGLE_QUARTER)) begin
            r_in[j] = a_ff[j] - 15'(ANGLE_QUARTER);
            u_in[j] = 13'(15'(ANGLE_QUARTER) - r_in[j]);
            neg_in[j] = 1'b0;
         end else begin
            r_in[j] = a_ff[j];
            u_in[j] = 13'(r_in[j]);
            neg_in[j] = 1'b0;
         end
         v_in[j] = V_W'(u_in[j]) * V_W'(SINE_TABLE_ENTRIES) + V_W'(ANGLE_QUARTER / 2);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) v1_ff[j] <= v_in[j];
      neg_ff[1] <= neg_in;
      for (int k = 2; k <= 4; k++) neg_ff[k] <= neg_ff[k-1];
   end

   // stage 2: reciprocal multiply for the divide by a quarter turn
   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         prod_ff[j] <= P_W'(v1_ff[j]) * P_W'(RECIP);
         v2_ff[j]   <= v1_ff[j];
      end
   end

   // stage 3: one-step correction and clamp to the table end
   logic [Q_W-1:0] q0_in [0:1];
   logic [Q_W-1:0] q1_in [0:1];
   logic [V_W:0]   rem_in [0:1];
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         q0_in[j]  = Q_W'(prod_ff[j] >> V_W);
         rem_in[j] = {1'b0, v2_ff[j]} - (V_W+1)'((V_W+1)'(q0_in[j]) * (V_W+1)'(ANGLE_QUARTER));
         q1_in[j]  = (rem_in[j] >= (V_W+1)'(ANGLE_QUARTER)) ? q0_in[j] + 1'b1 : q0_in[j];
         if (q1_in[j] > Q_W'(SINE_TABLE_ENTRIES)) q1_in[j] = Q_W'(SINE_TABLE_ENTRIES);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) idx_ff[j] <= q1_in[j][IDX_W-1:0];
   end

   // stage 4: table read
   always_ff @(posedge clock) begin
      mag_ff[0] <= SINE_ROM[idx_ff[0]];
      mag_ff[1] <= SINE_ROM[idx_ff[1]];
   end

   // stage 5: apply quadrant sign
   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         trig_ff[j] <= neg_ff[4][j] ? -$signed({1'b0, mag_ff[j]}) : $signed({1'b0, mag_ff[j]});
      end
   end

   // stage 6: rotation products (trig_ff[0] = sine, trig_ff[1] = cosine)
   always_ff @(posedge clock) begin
      xc_ff <= item_ff[5].vertex_x * trig_ff[1];
      zs_ff <= item_ff[5].vertex_z * trig_ff[0];
      zc_ff <= item_ff[5].vertex_z * trig_ff[1];
      xs_ff <= item_ff[5].vertex_x * trig_ff[0];
   end

   // stage 7: sum and round, halves up
   logic signed [32:0] xsum_in, zsum_in;
   always_comb begin
      xsum_in = 33'(xc_ff) + 33'(zs_ff) + 33'sd8192;
      zsum_in = 33'(zc_ff) - 33'(xs_ff) + 33'sd8192;
   end

   always_ff @(posedge clock) begin
      xr_ff <= 19'(xsum_in >>> 14);
      zr_ff <= 19'(zsum_in >>> 14);
   end

   // stage 8: depth with near clamp, numerators
   logic signed [19:0] d_in;
   logic signed [19:0] lim_in;
   always_comb begin
      d_in   = 20'(zr_ff) + $signed({5'b0, cfg.camera_distance});
      lim_in = (cfg.near_limit == '0) ? 20'sd1 : $signed({5'b0, cfg.near_limit});
   end

   always_ff @(posedge clock) begin
      clamp_ff <= (d_in < lim_in);
      d_ff     <= (d_in < lim_in) ? 17'(lim_in) : 17'(d_in);
      numx_ff  <= 32'(xr_ff * $signed({1'b0, cfg.focal_length}));
      numy_ff  <= 29'(item_ff[7].vertex_y * $signed({1'b0, cfg.focal_length}));
   end

   // stage 9: dividends 2*|num|*16 + d over 2*d
   logic [31:0] magx_in;
   logic [28:0] magy_in;
   always_comb begin
      magx_in = numx_ff[31] ? 32'(-numx_ff) : 32'(numx_ff);
      magy_in = numy_ff[28] ? 29'(-numy_ff) : 29'(numy_ff);
   end

   always_ff @(posedge clock) begin
      out_ff.num_x   <= DIV_NUM_W'({magx_in[30:0], 5'b0}) + DIV_NUM_W'(d_ff);
      out_ff.num_y   <= DIV_NUM_W'({magy_in, 5'b0}) + DIV_NUM_W'(d_ff);
      out_ff.den     <= {d_ff, 1'b0};
      out_ff.neg_x   <= numx_ff[31];
      out_ff.neg_y   <= numy_ff[28];
      out_ff.clamped <= clamp_ff;
   end

   assign out_valid = vld_ff[9];
   assign out_data  = out_ff;

   // divisor is twice a depth of at least one
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_data.den >= 18'd2)
      else $error("divisor below two");

endmodule

// File: hw/rtl/rypp_queue.sv
// ----------------------------------------------------------------------------
// rypp_queue
// Short FIFO between the front and the divider back end.
// ----------------------------------------------------------------------------
module rypp_queue
   import rypp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  div_req_type push_data,
   input  logic        pop,
   output logic        not_empty,
   output logic        full,
   output div_req_type pop_data
);

   div_req_type             mem_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]    count_ff, count_in;

   always_comb begin
      count_in = count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data  = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

// File: hw/rtl/rypp_back.sv
// ----------------------------------------------------------------------------
// rypp_back
// Pipelined restoring dividers (one quotient bit per stage), screen offset
// and output saturation.
// ----------------------------------------------------------------------------
module rypp_back
   import rypp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   input  div_req_type  in_data,
   output logic         rsp_valid,
   output rsp_data_type rsp_data
);

   logic [DIV_NUM_W:0]   vld_ff;
   div_req_type          st_ff [0:DIV_NUM_W];
   logic [DIV_DEN_W-1:0] rx_ff [0:DIV_NUM_W];
   logic [DIV_DEN_W-1:0] ry_ff [0:DIV_NUM_W];
   logic                 rsp_valid_ff;
   rsp_data_type         rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIV_NUM_W-1:0], in_valid};
      end
   end

   // stage entry
   always_ff @(posedge clock) begin
      st_ff[0] <= in_data;
      rx_ff[0] <= '0;
      ry_ff[0] <= '0;
   end

   // quotient bits shift into the dividend's low end
   for (genvar k = 0; k < DIV_NUM_W; k++) begin : g_div
      logic [DIV_DEN_W:0]   tx, ty;
      logic                 gx, gy;
      logic [DIV_DEN_W-1:0] nx, ny;
      div_req_type          nst;
      always_comb begin
         tx  = {rx_ff[k], st_ff[k].num_x[DIV_NUM_W-1]};
         ty  = {ry_ff[k], st_ff[k].num_y[DIV_NUM_W-1]};
         gx  = (tx >= {1'b0, st_ff[k].den});
         gy  = (ty >= {1'b0, st_ff[k].den});
         nx  = gx ? DIV_DEN_W'(tx - {1'b0, st_ff[k].den}) : DIV_DEN_W'(tx);
         ny  = gy ? DIV_DEN_W'(ty - {1'b0, st_ff[k].den}) : DIV_DEN_W'(ty);
         nst = st_ff[k];
         nst.num_x = {st_ff[k].num_x[DIV_NUM_W-2:0], gx};
         nst.num_y = {st_ff[k].num_y[DIV_NUM_W-2:0], gy};
      end
      always_ff @(posedge clock) begin
         st_ff[k+1] <= nst;
         rx_ff[k+1] <= nx;
         ry_ff[k+1] <= ny;
      end
   end

   function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
      logic signed [37:0] t;
      t = v;
      if (t > OUT_MAX) t = OUT_MAX;
      if (t < OUT_MIN) t = OUT_MIN;
      return t[23:0];
   endfunction

   // offset from center, y inverted
   logic signed [37:0] offx_in, offy_in, basex_in, basey_in;
   div_req_type        fin;
   always_comb begin
      fin      = st_ff[DIV_NUM_W];
      offx_in  = $signed({2'b0, fin.num_x});
      offy_in  = $signed({2'b0, fin.num_y});
      if (fin.neg_x) offx_in = -offx_in;
      if (fin.neg_y) offy_in = -offy_in;
      basex_in = $signed({22'b0, cfg.center_x, 4'b0});
      basey_in = $signed({22'b0, cfg.center_y, 4'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[DIV_NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.screen_x      <= sat24(basex_in + offx_in);
      rsp_ff.screen_y      <= sat24(basey_in - offy_in);
      rsp_ff.depth_clamped <= fin.clamped;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_to_rsp: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_NUM_W] |=> rsp_valid)
      else $error("finished division lost");

endmodule

// File: hw/rtl/rotate_y_perspective_project_unit.sv
// ----------------------------------------------------------------------------
// rotate_y_perspective_project_unit
// Rotates a Q4.12 vertex about Y and projects it to Q20.4 screen coordinates.
// ----------------------------------------------------------------------------
// Takes one vertex per cycle while busy is low and returns one result per vertex,
// in order, on a one-cycle rsp_valid strobe that the receiver cannot hold off.
// Each vertex passes through the 36-stage bit-per-stage divider behind a 10-stage
// rotation front end; busy only rises if the front/back queue fills. The user
// writes registers over the APB-style csr_ port only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rotate_y_perspective_project_unit
   import rypp_pkg::*;
#(
   parameter int unsigned SINE_TABLE_ENTRIES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_valid,
   output rsp_data_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type       cfg_ff;
   logic          csr_wr;
   csr_index_type csr_idx;
   logic          accept;
   logic          f_valid, q_full, q_valid;
   div_req_type   f_data, q_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[4:2]);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_distance <= CAMERA_DISTANCE_RST;
         cfg_ff.near_limit      <= NEAR_LIMIT_RST;
         cfg_ff.focal_length    <= FOCAL_LENGTH_RST;
         cfg_ff.center_x        <= CENTER_X_RST;
         cfg_ff.center_y        <= CENTER_Y_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_CAMERA_DISTANCE: cfg_ff.camera_distance <= csr_pwdata[14:0];
            CSR_NEAR_LIMIT:      cfg_ff.near_limit      <= csr_pwdata[14:0];
            CSR_FOCAL_LENGTH:    cfg_ff.focal_length    <= csr_pwdata[11:0];
            CSR_CENTER_X:        cfg_ff.center_x        <= csr_pwdata[11:0];
            CSR_CENTER_Y:        cfg_ff.center_y        <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_idx)
         CSR_CAMERA_DISTANCE: csr_prdata = {17'b0, cfg_ff.camera_distance};
         CSR_NEAR_LIMIT:      csr_prdata = {17'b0, cfg_ff.near_limit};
         CSR_FOCAL_LENGTH:    csr_prdata = {20'b0, cfg_ff.focal_length};
         CSR_CENTER_X:        csr_prdata = {20'b0, cfg_ff.center_x};
         CSR_CENTER_Y:        csr_prdata = {20'b0, cfg_ff.center_y};
         default:             csr_prdata = '0;
      endcase
   end

   assign busy   = q_full;
   assign accept = start & ~busy;

   rypp_front #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   rypp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_data),
      .pop       (q_valid),
      .not_empty (q_valid),
      .full      (q_full),
      .pop_data  (q_data)
   );

   rypp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (q_valid),
      .in_data   (q_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/tb_rotate_y_perspective_project_unit.sv
// ----------------------------------------------------------------------------
// tb_rotate_y_perspective_project_unit
// Self-checking testbench for the Y-rotation perspective projection unit.
// ----------------------------------------------------------------------------
// A bit-exact predictor computes the screen result of every accepted vertex
// transaction from a private copy of the registers and the sine table. A
// checker compares each rsp_valid strobe with the oldest pending prediction.
// Directed vertices and register sweeps come first, then random vertices
// under several register settings, with random idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb_rotate_y_perspective_project_unit;
   import rypp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_ENTRIES = 1024;
   localparam int unsigned DRAIN_CYCLES  = 60;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam longint      SCREEN_MAX    = 64'sd8388607;
   localparam longint      SCREEN_MIN    = -64'sd8388608;
   localparam longint unsigned PI_Q30    = 64'd3373259426;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_data_type req_data = '0;
   logic         rsp_valid;
   rsp_data_type rsp_data;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   rotate_y_perspective_project_unit #(.SINE_TABLE_ENTRIES(TABLE_ENTRIES)) dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [15:0]  quarter_sine [0:TABLE_ENTRIES];
   cfg_type      shadow_cfg;
   rsp_data_type pending_points [$];
   int           mismatch_count = 0;
   int           stall_cycles = 0;
   bit           no_idle = 0;

   // quarter-wave sine table, Q1.14, integer series expansion
   task automatic build_sine_table();
      longint unsigned x, x2, term, pos, neg, s;
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         x = (longint'(i) * PI_Q30) / (2 * TABLE_ENTRIES);
         x2 = (x * x) >> 30;
         term = x;
         pos = x;
         neg = 0;
         for (int k = 1; k <= 9; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k & 1) neg += term;
            else pos += term;
         end
         s = (pos > neg) ? pos - neg : 0;
         s = (s + 32768) >> 16;
         if (s > 16384) s = 16384;
         quarter_sine[i] = s[15:0];
      end
   endtask

   function automatic longint sine_lookup(int unsigned a);
      int unsigned quad, r, u, idx;
      quad = a / ANGLE_QUARTER;
      r = a % ANGLE_QUARTER;
      u = (quad & 1) ? ANGLE_QUARTER - r : r;
      idx = (u * TABLE_ENTRIES + ANGLE_QUARTER / 2) / ANGLE_QUARTER;
      if (idx > TABLE_ENTRIES) idx = TABLE_ENTRIES;
      return (quad >= 2) ? -longint'(quarter_sine[idx]) : longint'(quarter_sine[idx]);
   endfunction

   function automatic longint round_divide(longint n, longint d);
      longint unsigned mag, q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [23:0] saturate_screen(longint v);
      if (v > SCREEN_MAX) v = SCREEN_MAX;
      if (v < SCREEN_MIN) v = SCREEN_MIN;
      return v[23:0];
   endfunction

   function automatic rsp_data_type project_vertex(req_data_type v, cfg_type c);
      longint       x, y, z, red, s, co, xr, zr, d, lim, sx, sy;
      int unsigned  a;
      rsp_data_type r;
      x = v.vertex_x;
      y = v.vertex_y;
      z = v.vertex_z;
      red = longint'(v.angle) % longint'(ANGLE_FULL);
      if (red < 0) red += ANGLE_FULL;
      a = 32'(red);
      s = sine_lookup(a);
      co = sine_lookup((a + ANGLE_QUARTER) % ANGLE_FULL);
      xr = (x * co + z * s + 8192) >>> 14;
      zr = (z * co - x * s + 8192) >>> 14;
      lim = (c.near_limit == 0) ? 1 : longint'(c.near_limit);
      d = zr + longint'(c.camera_distance);
      r.depth_clamped = 1'b0;
      if (d < lim) begin
         d = lim;
         r.depth_clamped = 1'b1;
      end
      sx = longint'(c.center_x) * 16 + round_divide(xr * longint'(c.focal_length) * 16, d);
      sy = longint'(c.center_y) * 16 - round_divide(y * longint'(c.focal_length) * 16, d);
      r.screen_x = saturate_screen(sx);
      r.screen_y = saturate_screen(sy);
      return r;
   endfunction

   // result checker and stall watchdog
   always @(posedge clock) begin
      rsp_data_type exp_pt;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL rotate_y_perspective_project_unit");
            $finish;
         end
      end
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: %h", rsp_data);
         end else begin
            exp_pt = pending_points.pop_front();
            if (rsp_data.screen_x !== exp_pt.screen_x || rsp_data.screen_y !== exp_pt.screen_y
                || rsp_data.depth_clamped !== exp_pt.depth_clamped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp x=%0d y=%0d c=%0b got x=%0d y=%0d c=%0b",
                           exp_pt.screen_x, exp_pt.screen_y, exp_pt.depth_clamped,
                           rsp_data.screen_x, rsp_data.screen_y, rsp_data.depth_clamped);
            end
         end
      end
   end

   // one vertex transaction, start held high across back-to-back items
   task automatic send_vertex(req_data_type v);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= v;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_points.push_back(project_vertex(v, shadow_cfg));
   endtask

   task automatic drain();
      start <= 1'b0;
      wait (pending_points.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access; out-of-range index is ignored by the block
   task automatic write_reg(int unsigned idx, logic [31:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(idx * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         CSR_CAMERA_DISTANCE: shadow_cfg.camera_distance = value[14:0];
         CSR_NEAR_LIMIT:      shadow_cfg.near_limit = value[14:0];
         CSR_FOCAL_LENGTH:    shadow_cfg.focal_length = value[11:0];
         CSR_CENTER_X:        shadow_cfg.center_x = value[11:0];
         CSR_CENTER_Y:        shadow_cfg.center_y = value[11:0];
         default: ;
      endcase
   endtask

   task automatic set_all(int unsigned cam, int unsigned nl, int unsigned f,
                          int unsigned cx, int unsigned cy);
      write_reg(CSR_CAMERA_DISTANCE, cam);
      write_reg(CSR_NEAR_LIMIT, nl);
      write_reg(CSR_FOCAL_LENGTH, f);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
   endtask

   function automatic req_data_type make_vertex(int x, int y, int z, int a);
      req_data_type v;
      v.vertex_x = 16'(x);
      v.vertex_y = 16'(y);
      v.vertex_z = 16'(z);
      v.angle = 16'(a);
      return v;
   endfunction

   function automatic logic [15:0] rand_coord();
      int m;
      m = $urandom_range(0, 19);
      if (m < 13) return 16'($urandom);
      if (m < 17) return 16'($urandom_range(0, 16384) - 8192);
      return m[0] ? 16'h7fff : 16'h8000;
   endfunction

   function automatic req_data_type rand_vertex();
      int m;
      m = $urandom_range(0, 9);
      return make_vertex(rand_coord(), rand_coord(), rand_coord(),
                         (m == 0) ? $urandom : $urandom_range(0, 46079) - 23040);
   endfunction

   // extremes of every field and the named angle cases
   task automatic test_directed();
      send_vertex(make_vertex(0, 0, 0, 0));
      send_vertex(make_vertex(4096, 4096, 4096, 0));
      send_vertex(make_vertex(4096, -4096, 0, 5760));
      send_vertex(make_vertex(4096, 4096, 0, 11520));
      send_vertex(make_vertex(4096, 4096, 0, 17280));
      send_vertex(make_vertex(4096, 4096, 4096, -23040));
      send_vertex(make_vertex(4096, 4096, 4096, 23039));
      send_vertex(make_vertex(4096, 4096, 4096, -32768));
      send_vertex(make_vertex(4096, 4096, 4096, 32767));
      send_vertex(make_vertex(32767, 32767, 32767, 0));
      send_vertex(make_vertex(-32768, -32768, -32768, 0));
      send_vertex(make_vertex(32767, -32768, -32768, 2880));
      send_vertex(make_vertex(-32768, 32767, 32767, -2880));
      send_vertex(make_vertex(0, 0, -20070, 0));
      send_vertex(make_vertex(100, 100, -32768, 0));
      send_vertex(make_vertex(-1, -1, -1, -1));
   endtask

   // saturation, zero near limit, zero focal length, ignored index
   task automatic test_register_edges();
      set_all(0, 1, 4095, 4095, 0);
      test_directed();
      set_all(32767, 0, 0, 0, 4095);
      write_reg(5, 32'hffff_ffff);
      write_reg(7, 32'h0000_1234);
      test_directed();
      set_all(0, 0, 4095, 0, 0);
      repeat (8) send_vertex(rand_vertex());
      set_all(32767, 32767, 1, 4095, 4095);
      repeat (8) send_vertex(rand_vertex());
   endtask

   task automatic test_random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if ((i % 40) == 0) no_idle = ($urandom_range(0, 3) == 0);
         send_vertex(rand_vertex());
      end
      no_idle = 0;
   endtask

   task automatic test_random();
      set_all(20480, 410, 500, 500, 400);
      test_random_phase(150);
      set_all($urandom | 32'hffff_8000, $urandom_range(0, 32767), $urandom_range(1, 4095),
              $urandom_range(0, 4095), $urandom_range(0, 4095));
      test_random_phase(150);
      set_all(4096, 1, 4095, 2048, 2048);
      test_random_phase(100);
      set_all($urandom_range(0, 32767), $urandom_range(1, 8192), $urandom | 32'hffff_f000,
              $urandom_range(0, 4095), $urandom_range(0, 4095));
      test_random_phase(150);
      set_all(32767, 16384, 4095, 0, 4095);
      test_random_phase(36);
   endtask

   initial begin
      build_sine_table();
      shadow_cfg = '{CAMERA_DISTANCE_RST, NEAR_LIMIT_RST, FOCAL_LENGTH_RST,
                     CENTER_X_RST, CENTER_Y_RST};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_edges();
      test_random();
      drain();
      if (mismatch_count == 0 && pending_points.size() == 0)
         $display("PASS rotate_y_perspective_project_unit");
      else
         $display("FAIL rotate_y_perspective_project_unit");
      $finish;
   end

endmodule
